/* hw/rtl/shift_pattern_match_detector_defines.svh */
// ----------------------------------------------------------------------------
// Shift pattern match detector assertion macros
// Short forms for the concurrent checks of the detector's checker.
// ----------------------------------------------------------------------------
`ifndef SHIFT_PATTERN_MATCH_DETECTOR_DEFINES_SVH
`define SHIFT_PATTERN_MATCH_DETECTOR_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define SPMD_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// Same-cycle implication outside reset.
`define SPMD_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication outside reset.
`define SPMD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/spmd_pkg.sv */
// ----------------------------------------------------------------------------
// Shift pattern match detector package
// Shared constants, codes and types of the detector.
// ----------------------------------------------------------------------------
`default_nettype none

package spmd_pkg;

    localparam int MAX_PATTERN = 64;
    localparam int IDX_W       = $clog2(MAX_PATTERN);
    localparam int LEN_W       = 7;
    localparam int LIMIT_W     = 8;
    localparam int CNT_W       = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 64;

    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BITS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_LIMIT     = 2'd2;

    localparam logic [MAX_PATTERN-1:0] PATTERN_BITS_RESET   = '0;
    localparam logic [LEN_W-1:0]       PATTERN_LENGTH_RESET = 7'd8;
    localparam logic [LIMIT_W-1:0]     STEP_LIMIT_RESET     = 8'd128;

    localparam logic CMD_START  = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    typedef enum logic [1:0] {
        VERDICT_NONE   = 2'd0,
        VERDICT_MATCH  = 2'd1,
        VERDICT_ACTIVE = 2'd2
    } verdict_t;

    typedef struct packed {
        logic             drive_bit;
        logic             scan_running;
        logic             scan_done;
        verdict_t         verdict;
        logic [CNT_W-1:0] delay_bits;
        logic [CNT_W-1:0] toggle_total;
    } result_t;

    typedef struct packed {
        logic clear;
        logic shift;
    } cell_ctl_t;

endpackage

`default_nettype wire

/* hw/rtl/spmd_cell.sv */
// ----------------------------------------------------------------------------
// Window cell
// Holds one bit of the sample window and compares its next value with the
// pattern bit at its position.
// ----------------------------------------------------------------------------
`default_nettype none

module spmd_cell (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire spmd_pkg::cell_ctl_t ctl,
    input  wire logic              in_use,
    input  wire logic              is_top,
    input  wire logic              upper_bit,
    input  wire logic              line_level,
    input  wire logic              pattern_bit,
    output logic                   window_bit,
    output logic                   bit_match
);

    logic bit_reg;
    logic bit_next;
    logic shifted;

    // The top cell in use takes the new sample; cells past the length empty.
    always_comb begin
        shifted = in_use ? (is_top ? line_level : upper_bit) : 1'b0;
        if (ctl.clear) begin
            bit_next = 1'b0;
        end else if (ctl.shift) begin
            bit_next = shifted;
        end else begin
            bit_next = bit_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_reg <= 1'b0;
        end else begin
            bit_reg <= bit_next;
        end
    end

    assign window_bit = bit_reg;
    assign bit_match  = !in_use || (shifted == pattern_bit);

endmodule

`default_nettype wire

/* hw/rtl/spmd_outbuf.sv */
// ----------------------------------------------------------------------------
// Result skid buffer
// Output register with one skid entry, so the input side ready is a register.
// ----------------------------------------------------------------------------
`default_nettype none

module spmd_outbuf (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire spmd_pkg::result_t in_word,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output spmd_pkg::result_t      out_word
);

    logic              out_valid_reg;
    logic              out_valid_next;
    logic              skid_valid_reg;
    logic              skid_valid_next;
    spmd_pkg::result_t out_word_reg;
    spmd_pkg::result_t out_word_next;
    spmd_pkg::result_t skid_word_reg;
    spmd_pkg::result_t skid_word_next;
    logic              accept;
    logic              out_free;

    assign in_ready = !skid_valid_reg;
    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_word_next   = out_word_reg;
        skid_word_next  = skid_word_reg;
        if (out_free) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_word_next   = skid_word_reg;
                skid_valid_next = 1'b0;
            end else if (accept) begin
                out_valid_next = 1'b1;
                out_word_next  = in_word;
            end else begin
                out_valid_next = 1'b0;
            end
        end else if (accept) begin
            skid_valid_next = 1'b1;
            skid_word_next  = in_word;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_word_reg  <= out_word_next;
        skid_word_reg <= skid_word_next;
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

`default_nettype wire

/* hw/rtl/shift_pattern_match_detector.sv */
// ----------------------------------------------------------------------------
// Shift pattern match detector
// Drives a configured pattern on a serial line and watches the return line
// for it, reporting a match with its delay or the line activity seen.
// ----------------------------------------------------------------------------
// Usage: the input channel (s_valid/s_ready) carries one word per step: a
// start word (s_cmd = 0, s_line_level = initial level) or a sample word
// (s_cmd = 1, s_line_level = sampled return level). Every accepted word
// yields exactly one result word on the m_ channel, in order. Sample words
// that arrive while no scan runs give an all-zero result and change nothing.
// Each result is registered in the output buffer; one word is taken every
// cycle while s_ready is high, the step state updated by the window chain.
// The result side has an output register plus one skid entry: when the
// receiver stalls, one more word is accepted and parked, after which s_ready
// drops until the receiver takes a word. s_ready comes from a register.
// Configuration (cfg_we, cfg_index, cfg_wdata) is written between scans:
// index 0 pattern bits, 1 pattern length, 2 step limit; other indexes are
// ignored. Synchronous active-low reset returns the registers to their
// defaults, clears the window and counters and leaves the scan idle.
// ----------------------------------------------------------------------------
`default_nettype none

module shift_pattern_match_detector (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    // Configuration write port
    input  wire logic                                  cfg_we,
    input  wire logic [spmd_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [spmd_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    // Input words
    input  wire logic                                  s_valid,
    output logic                                       s_ready,
    input  wire logic                                  s_cmd,
    input  wire logic                                  s_line_level,
    // Result words
    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output logic                                       m_drive_bit,
    output logic                                       m_scan_running,
    output logic                                       m_scan_done,
    output logic [1:0]                                 m_verdict,
    output logic [spmd_pkg::CNT_W-1:0]                 m_delay_bits,
    output logic [spmd_pkg::CNT_W-1:0]                 m_toggle_total
);

    localparam int MAXP  = spmd_pkg::MAX_PATTERN;
    localparam int IDXW  = spmd_pkg::IDX_W;
    localparam int LENW  = spmd_pkg::LEN_W;
    localparam int CNTW  = spmd_pkg::CNT_W;
    localparam int LIMW  = spmd_pkg::LIMIT_W;

    // Configuration registers.
    logic [MAXP-1:0] pattern_bits_reg;
    logic [LENW-1:0] pattern_length_reg;
    logic [LIMW-1:0] step_limit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_bits_reg   <= spmd_pkg::PATTERN_BITS_RESET;
            pattern_length_reg <= spmd_pkg::PATTERN_LENGTH_RESET;
            step_limit_reg     <= spmd_pkg::STEP_LIMIT_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                spmd_pkg::REG_PATTERN_BITS: begin
                    pattern_bits_reg <= cfg_wdata[MAXP-1:0];
                end
                spmd_pkg::REG_PATTERN_LENGTH: begin
                    pattern_length_reg <= cfg_wdata[LENW-1:0];
                end
                spmd_pkg::REG_STEP_LIMIT: begin
                    step_limit_reg <= cfg_wdata[LIMW-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // The length in use is the configured length clamped to 1..MAX_PATTERN.
    logic [LENW-1:0] len_eff;

    always_comb begin
        if (pattern_length_reg == '0) begin
            len_eff = LENW'(1);
        end else if (pattern_length_reg > LENW'(MAXP)) begin
            len_eff = LENW'(MAXP);
        end else begin
            len_eff = pattern_length_reg;
        end
    end

    // Step state.
    logic [IDXW-1:0] send_idx_reg;
    logic [IDXW-1:0] send_idx_next;
    logic [CNTW-1:0] step_cnt_reg;
    logic [CNTW-1:0] step_cnt_next;
    logic [CNTW-1:0] toggle_cnt_reg;
    logic [CNTW-1:0] toggle_cnt_next;
    logic            prev_level_reg;
    logic            prev_level_next;
    logic            active_reg;
    logic            active_next;

    logic                 in_ready;
    logic                 accept;
    logic                 do_start;
    logic                 do_sample;
    spmd_pkg::cell_ctl_t  cell_ctl;
    spmd_pkg::result_t    result;
    spmd_pkg::result_t    out_word;

    assign accept    = s_valid && in_ready;
    assign do_start  = accept && (s_cmd == spmd_pkg::CMD_START);
    assign do_sample = accept && (s_cmd == spmd_pkg::CMD_SAMPLE) && active_reg;

    assign cell_ctl.clear = do_start;
    assign cell_ctl.shift = do_sample;

    // The window is a row of cells; each sample shifts the row down by one,
    // the newest sample entering at the cell just below the pattern length.
    logic [MAXP-1:0] window_bits;
    logic [MAXP-1:0] cell_match;

    for (genvar i = 0; i < MAXP; i++) begin : g_cell
        logic upper;
        if (i == MAXP - 1) begin : g_last
            assign upper = 1'b0;
        end else begin : g_mid
            assign upper = window_bits[i+1];
        end

        spmd_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctl         (cell_ctl),
            .in_use      (LENW'(i) < len_eff),
            .is_top      (LENW'(i) == (len_eff - LENW'(1))),
            .upper_bit   (upper),
            .line_level  (s_line_level),
            .pattern_bit (pattern_bits_reg[i]),
            .window_bit  (window_bits[i]),
            .bit_match   (cell_match[i])
        );
    end

    // Per-sample arithmetic.
    logic [LENW-1:0] idx_inc;
    logic [CNTW:0]   steps_taken;
    logic            window_equal;
    logic            matched;
    logic            limit_hit;
    logic            toggled;
    logic [CNTW:0]   delay_full;

    assign idx_inc      = {1'b0, send_idx_reg} + LENW'(1);
    assign steps_taken  = {1'b0, step_cnt_reg} + (CNTW+1)'(1);
    assign window_equal = &cell_match;
    assign matched      = (steps_taken >= (CNTW+1)'(len_eff)) && window_equal;
    assign limit_hit    = steps_taken >= (CNTW+1)'(step_limit_reg);
    assign toggled      = (s_line_level != prev_level_reg) && (toggle_cnt_reg != '1);
    assign delay_full   = steps_taken - (CNTW+1)'(len_eff);

    // Next state.
    always_comb begin
        send_idx_next   = send_idx_reg;
        step_cnt_next   = step_cnt_reg;
        toggle_cnt_next = toggle_cnt_reg;
        prev_level_next = prev_level_reg;
        active_next     = active_reg;
        if (do_start) begin
            send_idx_next   = '0;
            step_cnt_next   = '0;
            toggle_cnt_next = '0;
            prev_level_next = s_line_level;
            active_next     = (step_limit_reg != '0);
        end else if (do_sample) begin
            send_idx_next   = (idx_inc >= len_eff) ? '0 : idx_inc[IDXW-1:0];
            step_cnt_next   = steps_taken[CNTW] ? '1 : steps_taken[CNTW-1:0];
            toggle_cnt_next = toggled ? (toggle_cnt_reg + CNTW'(1)) : toggle_cnt_reg;
            prev_level_next = s_line_level;
            active_next     = !(matched || limit_hit);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            send_idx_reg   <= '0;
            step_cnt_reg   <= '0;
            toggle_cnt_reg <= '0;
            prev_level_reg <= 1'b0;
            active_reg     <= 1'b0;
        end else begin
            send_idx_reg   <= send_idx_next;
            step_cnt_reg   <= step_cnt_next;
            toggle_cnt_reg <= toggle_cnt_next;
            prev_level_reg <= prev_level_next;
            active_reg     <= active_next;
        end
    end

    // Result of the accepted word. A start with a nonzero step limit, or a
    // sample that keeps the scan going, reports the next pattern bit to drive;
    // a sample while idle reports all zero.
    always_comb begin
        result = '0;
        result.verdict = spmd_pkg::VERDICT_NONE;
        if (accept && (s_cmd == spmd_pkg::CMD_START)) begin
            if (step_limit_reg == '0) begin
                result.scan_done = 1'b1;
            end else begin
                result.drive_bit    = pattern_bits_reg[0];
                result.scan_running = 1'b1;
            end
        end else if (do_sample) begin
            if (matched) begin
                result.scan_done  = 1'b1;
                result.verdict    = spmd_pkg::VERDICT_MATCH;
                result.delay_bits = delay_full[CNTW-1:0];
            end else if (limit_hit) begin
                result.scan_done = 1'b1;
                if (toggle_cnt_next > CNTW'(1)) begin
                    result.verdict      = spmd_pkg::VERDICT_ACTIVE;
                    result.toggle_total = toggle_cnt_next;
                end
            end else begin
                result.drive_bit    = pattern_bits_reg[send_idx_next];
                result.scan_running = 1'b1;
            end
        end
    end

    spmd_outbuf u_outbuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (in_ready),
        .in_word   (result),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_word  (out_word)
    );

    assign s_ready        = in_ready;
    assign m_drive_bit    = out_word.drive_bit;
    assign m_scan_running = out_word.scan_running;
    assign m_scan_done    = out_word.scan_done;
    assign m_verdict      = out_word.verdict;
    assign m_delay_bits   = out_word.delay_bits;
    assign m_toggle_total = out_word.toggle_total;

endmodule

`default_nettype wire

/* hw/rtl/spmd_checker.sv */
// ----------------------------------------------------------------------------
// Shift pattern match detector checker
// Port-level checks on the result words, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "shift_pattern_match_detector_defines.svh"

module spmd_checker (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            m_valid,
    input  wire logic                            m_ready,
    input  wire logic                            m_drive_bit,
    input  wire logic                            m_scan_running,
    input  wire logic                            m_scan_done,
    input  wire logic [1:0]                      m_verdict,
    input  wire logic [spmd_pkg::CNT_W-1:0]      m_delay_bits,
    input  wire logic [spmd_pkg::CNT_W-1:0]      m_toggle_total
);

    // A stalled result word stays put.
    `SPMD_ASSERT_NEXT(a_stall_hold, m_valid && !m_ready, m_valid && $stable(m_delay_bits) && $stable(m_verdict), "result word changed while stalled")

    // A word that ends the scan never also asks for more samples.
    `SPMD_ASSERT_IMPL(a_done_not_running, m_valid && m_scan_done, !m_scan_running, "scan reported done and running at once")

    // The delay is only reported with a match.
    `SPMD_ASSERT_IMPL(a_delay_on_match, m_valid && (m_verdict != spmd_pkg::VERDICT_MATCH), m_delay_bits == '0, "delay reported without a match")

    // The toggle total is only reported with line activity.
    `SPMD_ASSERT_IMPL(a_toggles_on_active, m_valid && (m_verdict != spmd_pkg::VERDICT_ACTIVE), m_toggle_total == '0, "toggle total reported without activity")

    // Nothing is driven once the scan has stopped.
    `SPMD_ASSERT_IMPL(a_drive_when_running, m_valid && !m_scan_running, !m_drive_bit && (m_scan_done || (m_verdict == spmd_pkg::VERDICT_NONE)), "drive bit set while not running")

endmodule

bind shift_pattern_match_detector spmd_checker u_spmd_checker (.*);

`default_nettype wire
